### design/glob_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// No dependencies; imported by glob_match, wildcard_glob_matcher and glob_chk.
package glob_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_SUBJECT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [SYM_W-1:0] symbol;
        logic             has_symbol;
        logic             last;
    } item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] pat_len;
        logic [LEN_W-1:0] sub_len;
    } match_req_t;

    typedef struct packed {
        logic done;
        logic matched;
    } match_rsp_t;

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_MATCH = 3'b010,
        T_EMIT  = 3'b100
    } top_state_t;

    typedef enum logic [4:0] {
        M_IDLE      = 5'b00001,
        M_READ      = 5'b00010,
        M_CMP       = 5'b00100,
        M_TAIL_READ = 5'b01000,
        M_TAIL_CMP  = 5'b10000
    } match_state_t;

endpackage

### design/glob_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module glob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/glob_match.sv
// Match sequencer: greedy scan with backtracking to the last star.
// One compare per step against the pattern and subject RAMs; uses glob_pkg.
module glob_match
    import glob_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  match_req_t        req,
    output logic [ADDR_W-1:0] pat_addr,
    output logic [ADDR_W-1:0] sub_addr,
    input  logic [SYM_W-1:0]  pat_data,
    input  logic [SYM_W-1:0]  sub_data,
    output match_rsp_t        rsp
);

    match_state_t     state_reg, state_next;
    match_rsp_t       rsp_reg, rsp_next;
    logic [LEN_W-1:0] p_reg, p_next, s_reg, s_next;
    logic [LEN_W-1:0] mark_p_reg, mark_p_next, mark_s_reg, mark_s_next;
    logic [LEN_W-1:0] pl_reg, pl_next, sl_reg, sl_next;
    logic             lead_reg, lead_next;

    logic [SYM_W-1:0] pc;
    logic             star, hit;
    logic [LEN_W-1:0] p_inc, s_inc, mark_s_inc;

    assign pat_addr = p_reg[ADDR_W-1:0];
    assign sub_addr = s_reg[ADDR_W-1:0];
    assign rsp      = rsp_reg;

    always_comb
    begin
        pc         = (p_reg < pl_reg) ? pat_data : '0;
        star       = (pc == SYM_STAR);
        hit        = (pc == sub_data) || (pc == SYM_ANY);
        p_inc      = p_reg + LEN_W'(1);
        s_inc      = s_reg + LEN_W'(1);
        mark_s_inc = mark_s_reg + LEN_W'(1);

        state_next  = state_reg;
        rsp_next    = '{done: 1'b0, matched: rsp_reg.matched};
        p_next      = p_reg;
        s_next      = s_reg;
        mark_p_next = mark_p_reg;
        mark_s_next = mark_s_reg;
        pl_next     = pl_reg;
        sl_next     = sl_reg;
        lead_next   = lead_reg;

        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    pl_next     = req.pat_len;
                    sl_next     = req.sub_len;
                    p_next      = '0;
                    s_next      = '0;
                    mark_p_next = '0;
                    mark_s_next = '0;
                    lead_next   = 1'b1;
                    state_next  = (req.sub_len == '0) ? M_TAIL_READ : M_READ;
                end
            end
            M_READ:
            begin
                state_next = M_CMP;
            end
            M_CMP:
            begin
                if (star)
                begin
                    if (lead_reg)
                    begin
                        lead_next = 1'b0;
                    end
                    else if (p_inc >= pl_reg)
                    begin
                        state_next = M_IDLE;
                        rsp_next   = '{done: 1'b1, matched: 1'b1};
                    end
                    else
                    begin
                        p_next      = p_inc;
                        mark_p_next = p_inc;
                        mark_s_next = s_inc;
                        state_next  = M_READ;
                    end
                end
                else if (hit)
                begin
                    p_next     = p_inc;
                    s_next     = s_inc;
                    state_next = (s_inc < sl_reg) ? M_READ : M_TAIL_READ;
                end
                else if (lead_reg)
                begin
                    state_next = M_IDLE;
                    rsp_next   = '{done: 1'b1, matched: 1'b0};
                end
                else
                begin
                    p_next      = mark_p_reg;
                    s_next      = mark_s_reg;
                    mark_s_next = mark_s_inc;
                    state_next  = (mark_s_reg < sl_reg) ? M_READ : M_TAIL_READ;
                end
            end
            M_TAIL_READ:
            begin
                state_next = M_TAIL_CMP;
            end
            M_TAIL_CMP:
            begin
                if (star)
                begin
                    p_next     = p_inc;
                    state_next = M_TAIL_READ;
                end
                else
                begin
                    state_next = M_IDLE;
                    rsp_next   = '{done: 1'b1, matched: (p_reg >= pl_reg)};
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        s_reg      <= s_next;
        mark_p_reg <= mark_p_next;
        mark_s_reg <= mark_s_next;
        pl_reg     <= pl_next;
        sl_reg     <= sl_next;
        lead_reg   <= lead_next;
    end

endmodule

### design/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: loaders, stores, result register.
// Uses glob_pkg, glob_ram and glob_match.
//
// Usage:
//   item channel (item_valid/item_stall/item_data): pattern items (opcode 0)
//   load the pattern byte by byte, one item per cycle while item_stall is
//   low; it is kept for every later subject until a new pattern load
//   starts. Subject items (opcode 1) load the subject, one item per cycle
//   while item_stall is low; the one with last = 1 yields one result.
//   result channel (result_valid/result_stall/result_data): one item per
//   subject, with matched and overflow flags.
// On overflow the result skips the match and waits in pend_reg for the
//   output register; else the match steps through a single compare unit
//   fed by one read port on each store, a read then a compare per step;
//   steps grow up to about pattern length times subject length when
//   backtracking to a star. item_stall stays high from the last subject
//   item until the result is placed in the output register.
// Reset clears all lengths and flags; an empty pattern matches only an
//   empty subject. A stalled result holds while new items keep loading.
module wildcard_glob_matcher
    import glob_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    top_state_t       state_reg, state_next;
    logic [LEN_W-1:0] pat_len_reg, pat_len_next, sub_len_reg, sub_len_next;
    logic             pat_open_reg, pat_open_next;
    logic             pat_tl_reg, pat_tl_next, sub_tl_reg, sub_tl_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    result_t          pend_reg, pend_next;

    logic             acc, sym_ok;
    logic [LEN_W-1:0] pat_base;
    logic             pat_tl_base;
    logic             pat_wr, sub_wr;
    match_req_t       req;
    match_rsp_t       rsp;
    logic [ADDR_W-1:0] pat_rd_addr, sub_rd_addr;
    logic [SYM_W-1:0]  pat_rd_data, sub_rd_data;

    assign item_stall   = (state_reg != T_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_comb
    begin
        acc         = item_valid && !item_stall;
        sym_ok      = item_data.has_symbol && (item_data.symbol != '0);
        pat_base    = pat_open_reg ? pat_len_reg : '0;
        pat_tl_base = pat_open_reg ? pat_tl_reg : 1'b0;
        pat_wr      = acc && (item_data.opcode == OP_PATTERN) && sym_ok
                      && (pat_base < LEN_W'(MAX_LEN));
        sub_wr      = acc && (item_data.opcode == OP_SUBJECT) && sym_ok
                      && (sub_len_reg < LEN_W'(MAX_LEN));

        state_next     = state_reg;
        pat_len_next   = pat_len_reg;
        pat_open_next  = pat_open_reg;
        pat_tl_next    = pat_tl_reg;
        sub_len_next   = sub_len_reg;
        sub_tl_next    = sub_tl_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        req            = '{start: 1'b0, pat_len: pat_len_reg, sub_len: sub_len_reg};

        unique case (state_reg)
            T_IDLE:
            begin
                if (acc && (item_data.opcode == OP_PATTERN))
                begin
                    pat_len_next  = pat_base;
                    pat_tl_next   = pat_tl_base;
                    pat_open_next = !item_data.last;
                    if (sym_ok)
                    begin
                        if (pat_wr)
                        begin
                            pat_len_next = pat_base + LEN_W'(1);
                        end
                        else
                        begin
                            pat_tl_next = 1'b1;
                        end
                    end
                end
                else if (acc)
                begin
                    pat_open_next = 1'b0;
                    if (sym_ok)
                    begin
                        if (sub_wr)
                        begin
                            sub_len_next = sub_len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            sub_tl_next = 1'b1;
                        end
                    end
                    if (item_data.last)
                    begin
                        if (pat_tl_reg || sub_tl_next)
                        begin
                            pend_next  = '{matched: 1'b0, overflow: 1'b1};
                            state_next = T_EMIT;
                        end
                        else
                        begin
                            req        = '{start: 1'b1, pat_len: pat_len_reg,
                                           sub_len: sub_len_next};
                            state_next = T_MATCH;
                        end
                        sub_len_next = '0;
                        sub_tl_next  = 1'b0;
                    end
                end
            end
            T_MATCH:
            begin
                if (rsp.done)
                begin
                    pend_next  = '{matched: rsp.matched, overflow: 1'b0};
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pat_len_reg   <= '0;
            pat_open_reg  <= 1'b0;
            pat_tl_reg    <= 1'b0;
            sub_len_reg   <= '0;
            sub_tl_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pat_len_reg   <= pat_len_next;
            pat_open_reg  <= pat_open_next;
            pat_tl_reg    <= pat_tl_next;
            sub_len_reg   <= sub_len_next;
            sub_tl_reg    <= sub_tl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    glob_ram #(
        .WIDTH(SYM_W),
        .DEPTH(MAX_LEN)
    ) u_pat_ram (
        .clk    (clk),
        .wr_en  (pat_wr),
        .wr_addr(pat_base[ADDR_W-1:0]),
        .wr_data(item_data.symbol),
        .rd_addr(pat_rd_addr),
        .rd_data(pat_rd_data)
    );

    glob_ram #(
        .WIDTH(SYM_W),
        .DEPTH(MAX_LEN)
    ) u_sub_ram (
        .clk    (clk),
        .wr_en  (sub_wr),
        .wr_addr(sub_len_reg[ADDR_W-1:0]),
        .wr_data(item_data.symbol),
        .rd_addr(sub_rd_addr),
        .rd_data(sub_rd_data)
    );

    glob_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .pat_addr(pat_rd_addr),
        .sub_addr(sub_rd_addr),
        .pat_data(pat_rd_data),
        .sub_data(sub_rd_data),
        .rsp     (rsp)
    );

endmodule

### design/glob_chk.sv
// Port-level checker for the wildcard glob matcher, bound to the top level.
// Uses glob_pkg.
module glob_chk
    import glob_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item_data,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result item changed");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item_data.opcode == OP_SUBJECT && item_data.last
        |=> item_stall)
        else $error("not busy after last subject item");

    a_load_streams: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !(item_data.opcode == OP_SUBJECT && item_data.last)
        |=> !item_stall)
        else $error("byte load stalled");

    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.overflow |-> !result_data.matched)
        else $error("overflow result reports a match");

endmodule

bind wildcard_glob_matcher glob_chk u_glob_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item_data   (item_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
);

### verif/wildcard_glob_matcher_tb.sv
// Testbench for wildcard_glob_matcher: random pattern/subject loads, results checked in order.
// Depends on glob_pkg and the wildcard_glob_matcher RTL; self-contained otherwise.
module wildcard_glob_matcher_tb
    import glob_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 600;
    localparam logic [7:0] LETTER_A = 8'h61;

    typedef logic [7:0] sym_q_t[$];

    class glob_scoreboard;
        logic [7:0] pat_mem[MAX_LEN];
        int         pat_len  = 0;
        bit         pat_open = 0;
        bit         pat_ovf  = 0;
        logic [7:0] sub_mem[MAX_LEN];
        int         sub_len  = 0;
        bit         sub_ovf  = 0;
        result_t    expected_q[$];
        int         fail_count = 0;

        function logic [7:0] pat_at(int i);
            return (i < pat_len) ? pat_mem[i] : 8'h00;
        endfunction

        function logic [7:0] sub_at(int i);
            return (i < sub_len) ? sub_mem[i] : 8'h00;
        endfunction

        // greedy scan, backtracking only to the latest star
        function bit glob_match();
            int s      = 0;
            int p      = 0;
            int star_p = 0;
            int star_s = 0;
            while (s < sub_len && pat_at(p) != SYM_STAR)
            begin
                if (pat_at(p) != sub_at(s) && pat_at(p) != SYM_ANY)
                    return 1'b0;
                s++;
                p++;
            end
            while (s < sub_len)
            begin
                if (pat_at(p) == SYM_STAR)
                begin
                    p++;
                    if (p >= pat_len)
                        return 1'b1;
                    star_p = p;
                    star_s = s + 1;
                end
                else if (pat_at(p) == sub_at(s) || pat_at(p) == SYM_ANY)
                begin
                    p++;
                    s++;
                end
                else
                begin
                    p = star_p;
                    s = star_s;
                    star_s++;
                end
            end
            while (pat_at(p) == SYM_STAR)
                p++;
            return p >= pat_len;
        endfunction

        function void note_item(item_t it);
            bit      has = it.has_symbol && (it.symbol != 8'h00);
            result_t r;
            if (it.opcode == OP_PATTERN)
            begin
                if (!pat_open)
                begin
                    pat_len  = 0;
                    pat_ovf  = 0;
                    pat_open = 1;
                end
                if (has)
                begin
                    if (pat_len < MAX_LEN)
                    begin
                        pat_mem[pat_len] = it.symbol;
                        pat_len++;
                    end
                    else
                        pat_ovf = 1;
                end
                if (it.last)
                    pat_open = 0;
            end
            else
            begin
                pat_open = 0;
                if (has)
                begin
                    if (sub_len < MAX_LEN)
                    begin
                        sub_mem[sub_len] = it.symbol;
                        sub_len++;
                    end
                    else
                        sub_ovf = 1;
                end
                if (it.last)
                begin
                    if (pat_ovf || sub_ovf)
                    begin
                        r.matched  = 1'b0;
                        r.overflow = 1'b1;
                    end
                    else
                    begin
                        r.matched  = glob_match();
                        r.overflow = 1'b0;
                    end
                    expected_q.push_back(r);
                    sub_len = 0;
                    sub_ovf = 0;
                end
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: matched=%0b overflow=%0b", got.matched, got.overflow);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.matched !== want.matched)
            begin
                $error("matched: expected %0b, got %0b", want.matched, got.matched);
                fail_count++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                fail_count++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item_data;
    logic    result_valid;
    logic    result_stall;
    result_t result_data;

    glob_scoreboard board = new;
    int sent_count    = 0;
    int cycle_count   = 0;
    bit tx_idle_on    = 1;
    bit rx_idle_on    = 1;
    bit long_hold_req = 0;

    wildcard_glob_matcher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // result side: check accepted items, stall in random bursts
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                board.check_result(result_data);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 11);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    function automatic item_t mk_item(logic op, logic [7:0] sym, logic has, logic last);
        item_t it;
        it.opcode     = op;
        it.symbol     = sym;
        it.has_symbol = has;
        it.last       = last;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (tx_idle_on && $urandom_range(0, 15) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do @(posedge clk); while (item_stall);
        board.note_item(it);
        if ((it.has_symbol && it.symbol != 8'h00) || it.last)
            sent_count++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (board.expected_q.size() != 0);
    endtask

    function automatic logic [7:0] pattern_char(bit few_stars);
        int r = $urandom_range(0, 99);
        if (r < 25)
            return (few_stars && $urandom_range(0, 9) != 0) ? LETTER_A : SYM_STAR;
        if (r < 40)
            return SYM_ANY;
        if (r < 90)
            return LETTER_A + 8'($urandom_range(0, 2));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] subject_char();
        int r = $urandom_range(0, 99);
        if (r < 80)
            return LETTER_A + 8'($urandom_range(0, 2));
        if (r < 85)
            return $urandom_range(0, 1) ? SYM_STAR : SYM_ANY;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic sym_q_t make_pattern(bit long_str);
        sym_q_t q;
        int     n = long_str ? $urandom_range(56, 72) : $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
            q.push_back(pattern_char(long_str));
        return q;
    endfunction

    // mostly an expansion of the pattern, so that many subjects match
    function automatic sym_q_t make_subject(sym_q_t pat, bit long_str);
        sym_q_t q;
        int     n;
        if (long_str && $urandom_range(0, 1))
        begin
            n = $urandom_range(56, 72);
            for (int i = 0; i < n; i++)
                q.push_back(subject_char());
            return q;
        end
        foreach (pat[i])
        begin
            if (pat[i] == SYM_STAR)
            begin
                n = long_str ? $urandom_range(0, 1) : $urandom_range(0, 3);
                repeat (n) q.push_back(subject_char());
            end
            else if (pat[i] == SYM_ANY)
                q.push_back(subject_char());
            else
                q.push_back(pat[i]);
        end
        if ($urandom_range(0, 9) < 4)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (q.size() > 0)
                        q[$urandom_range(0, q.size() - 1)] = subject_char();
                end
                1:
                begin
                    if (q.size() > 0)
                        q.delete($urandom_range(0, q.size() - 1));
                end
                default:
                    q.insert($urandom_range(0, q.size()), subject_char());
            endcase
        end
        return q;
    endfunction

    // close = 0 leaves the load open; ignored items are mixed in now and then
    task automatic send_string(input logic op, input sym_q_t str, input bit close);
        item_t it;
        bit    marker;
        logic  has;
        marker = $urandom_range(0, 4) == 0;
        for (int i = 0; i < str.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                has = $urandom_range(0, 1);
                send_item(mk_item(op, has ? 8'h00 : 8'($urandom_range(0, 255)), has, 1'b0));
            end
            it = mk_item(op, str[i], 1'b1, close && !marker && (i == str.size() - 1));
            send_item(it);
        end
        if (close && (marker || str.size() == 0))
        begin
            has = $urandom_range(0, 1);
            send_item(mk_item(op, has ? 8'h00 : 8'($urandom_range(0, 255)), has, 1'b1));
        end
    endtask

    initial
    begin
        sym_q_t pat;
        sym_q_t sub;
        bit     long_str;
        bit     hold_done;
        bit     drain_done;
        hold_done  = 0;
        drain_done = 0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset
        send_item(mk_item(OP_SUBJECT, 8'h00, 1'b0, 1'b1));
        send_item(mk_item(OP_SUBJECT, LETTER_A, 1'b1, 1'b1));
        // lone star
        send_item(mk_item(OP_PATTERN, SYM_STAR, 1'b1, 1'b1));
        send_item(mk_item(OP_SUBJECT, 8'h00, 1'b0, 1'b1));
        send_item(mk_item(OP_SUBJECT, 8'h78, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, 8'h79, 1'b1, 1'b1));
        // a?c
        send_item(mk_item(OP_PATTERN, LETTER_A, 1'b1, 1'b0));
        send_item(mk_item(OP_PATTERN, SYM_ANY, 1'b1, 1'b0));
        send_item(mk_item(OP_PATTERN, LETTER_A + 8'd2, 1'b1, 1'b1));
        send_item(mk_item(OP_SUBJECT, LETTER_A, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A + 8'd1, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A + 8'd2, 1'b1, 1'b1));
        send_item(mk_item(OP_SUBJECT, LETTER_A, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A + 8'd2, 1'b1, 1'b1));
        // zero byte flagged valid is dropped
        send_item(mk_item(OP_SUBJECT, LETTER_A, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, 8'h00, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A + 8'd1, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A + 8'd2, 1'b1, 1'b1));
        // byte extremes
        send_item(mk_item(OP_PATTERN, 8'hFF, 1'b1, 1'b0));
        send_item(mk_item(OP_PATTERN, 8'h01, 1'b1, 1'b1));
        send_item(mk_item(OP_SUBJECT, 8'hFF, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, 8'h01, 1'b1, 1'b1));
        // subject arrives while the pattern is still open
        send_item(mk_item(OP_PATTERN, LETTER_A, 1'b1, 1'b0));
        send_item(mk_item(OP_SUBJECT, LETTER_A, 1'b1, 1'b1));

        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count > ITEM_TARGET - 150)
            begin
                tx_idle_on = 0;
                rx_idle_on = 0;
            end
            else
            begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (!hold_done && sent_count >= 500)
            begin
                long_hold_req = 1;
                hold_done = 1;
            end
            if (!drain_done && sent_count >= 900)
            begin
                drain_results();
                drain_done = 1;
            end
            long_str = $urandom_range(0, 24) == 0;
            pat = make_pattern(long_str);
            send_string(OP_PATTERN, pat, $urandom_range(0, 99) >= 8);
            repeat ($urandom_range(1, 4))
            begin
                sub = make_subject(pat, long_str);
                send_string(OP_SUBJECT, sub, $urandom_range(0, 19) != 0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.fail_count == 0 && board.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
